// File: hdl/sine_cosine_poly_approx_unit_defines.svh
// Assertion macros shared by the sine/cosine approximation unit.
`ifndef SINE_COSINE_POLY_APPROX_UNIT_DEFINES_SVH
`define SINE_COSINE_POLY_APPROX_UNIT_DEFINES_SVH
// Same-cycle implication, checked outside reset.
`define SCPA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked outside reset.
`define SCPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
// Next-cycle implication that is also checked while reset is applied.
`define SCPA_ASSERT_RESET(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);
`endif

// File: hdl/scpa_pkg.sv
// Types, constants and coefficients of the sine/cosine approximation unit.
package scpa_pkg;

  localparam int ANGLE_W              = 31;
  localparam int VALUE_W              = 18;
  localparam int ANGLE_FRAC_BITS_DEF  = 24;
  localparam int RESULT_FRAC_BITS_DEF = 16;

  // Polynomial datapath: accumulator Q2.30, reduced argument unsigned Q1.30.
  localparam int COEF_FRAC    = 30;
  localparam int ACC_W        = 32;
  localparam int ARG_W        = 31;
  localparam int PROD_W       = ACC_W + ARG_W + 1;
  localparam int HORNER_STEPS = 4;

  // pi scaled by 2^60.
  localparam logic [63:0] PI_Q60 = 64'd3622009729038561421;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [ARG_W-1:0]        arg_t;

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (COEF_FRAC - 1);

  // Leading coefficient, then the coefficient added after each Horner product.
  localparam acc_t C4 = 32'sd30920543;
  typedef acc_t coef_arr_t [HORNER_STEPS];
  localparam coef_arr_t HORNER_ADD = '{
    -32'sd219409152,
    32'sd22949092,
    32'sd1069045277,
    32'sd0
  };

  typedef struct packed {
    acc_t acc;
    arg_t arg;
    logic neg;
  } hrn_t;

endpackage

// File: hdl/scpa_if.sv
// Valid/ready channel interfaces for the angle input and the result output.
interface scpa_in_if;
  import scpa_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      func;
  logic signed [ANGLE_W-1:0] angle;

  modport source (output valid, output func, output angle, input ready);
  modport sink (input valid, input func, input angle, output ready);
endinterface

interface scpa_out_if;
  import scpa_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// File: hdl/scpa_range_reduce.sv
// Four-stage range reduction of the angle to an argument in [0, pi/2] and a sign.
`include "sine_cosine_poly_approx_unit_defines.svh"

module scpa_range_reduce #(
  parameter int ANGLE_FRAC_BITS = scpa_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  logic                              func,
  input  logic signed [scpa_pkg::ANGLE_W-1:0] angle,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output scpa_pkg::hrn_t                    dn_data
);
  import scpa_pkg::*;

  localparam int F           = ANGLE_FRAC_BITS;
  localparam int NS          = 4;
  localparam int X_W         = ANGLE_W + 1;
  localparam int X2_W        = X_W + 1;
  localparam int RECIP_SHIFT = X2_W;
  localparam int P_W         = F + 2;
  localparam int N_W         = RECIP_SHIFT - F;
  localparam int R_W         = N_W - 1;
  localparam int MUL_W       = X2_W + R_W + 1;
  localparam int NP_W        = N_W + P_W + 1;
  localparam int REM_W       = P_W + 2;

  localparam logic [63:0] P_FULL  = (PI_Q60 + (64'd1 << (59 - F))) >> (60 - F);
  localparam logic [63:0] PH_FULL = (PI_Q60 + (64'd1 << (60 - F))) >> (61 - F);
  localparam logic [63:0] R_FULL  = (64'd1 << RECIP_SHIFT) / P_FULL;

  localparam logic [P_W-1:0]          P     = P_FULL[P_W-1:0];
  localparam logic signed [REM_W-1:0] P_S   = $signed({2'b00, P_FULL[P_W-1:0]});
  localparam logic signed [X_W-1:0]   PH    = $signed(PH_FULL[X_W-1:0]);
  localparam logic [R_W-1:0]          RECIP = R_FULL[R_W-1:0];
  localparam arg_t ARG_MAX = ARG_W'((P_FULL >> 1) << (COEF_FRAC - F));

  logic [NS-1:0] v_r;
  logic [NS:0]   en;

  logic signed [X_W-1:0]   angle_x, x_nxt, x_r, x1_r;
  logic signed [MUL_W-1:0] mul_nxt, mul_r;
  logic signed [N_W-1:0]   n_est;
  logic signed [NP_W-1:0]  np, twox_w, rem_full;
  logic signed [REM_W-1:0] rem_nxt, rem_r, r_s;
  logic [1:0]              nlo_nxt, nlo_r, nlo_c;
  logic [P_W-1:0]          r_u, fold;
  arg_t                    arg_nxt, arg_r;
  logic                    neg_nxt, neg_r;

  // Stage enables: a stage loads when it is empty or its content moves on.
  always_comb begin
    en[NS] = dn_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= (en[NS-1:0] & {v_r[NS-2:0], up_valid}) | (~en[NS-1:0] & v_r);
    end
  end

  // Stage 0: cosine is the sine of pi/2 minus the angle.
  assign angle_x = {angle[ANGLE_W-1], angle};
  assign x_nxt   = func ? (PH - angle_x) : angle_x;

  // Stage 1: estimate of floor(2x/pi) by a reciprocal product.
  assign mul_nxt = $signed({x_r, 1'b0}) * $signed({1'b0, RECIP});

  // Stage 2: remainder of the estimate; it lies in [-pi, 2pi).
  always_comb begin
    n_est    = $signed(mul_r[MUL_W-1 -: N_W]);
    np       = n_est * $signed({1'b0, P});
    twox_w   = $signed({{(NP_W - X2_W){x1_r[X_W-1]}}, x1_r, 1'b0});
    rem_full = twox_w - np;
    rem_nxt  = rem_full[REM_W-1:0];
    nlo_nxt  = n_est[1:0];
  end

  // Stage 3: correct the quotient by one, then fold the remainder. For an even
  // quotient the argument is r/2, for an odd one (pi - r)/2.
  always_comb begin
    priority if (rem_r[REM_W-1]) begin
      r_s   = rem_r + P_S;
      nlo_c = nlo_r - 2'd1;
    end else if (rem_r >= P_S) begin
      r_s   = rem_r - P_S;
      nlo_c = nlo_r + 2'd1;
    end else begin
      r_s   = rem_r;
      nlo_c = nlo_r;
    end
    r_u     = r_s[P_W-1:0];
    fold    = nlo_c[0] ? (P - r_u) : r_u;
    arg_nxt = {fold[P_W-1:1], {(COEF_FRAC - F){1'b0}}};
    neg_nxt = nlo_c[1];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r <= x_nxt;
    end
    if (en[1]) begin
      mul_r <= mul_nxt;
      x1_r  <= x_r;
    end
    if (en[2]) begin
      rem_r <= rem_nxt;
      nlo_r <= nlo_nxt;
    end
    if (en[3]) begin
      arg_r <= arg_nxt;
      neg_r <= neg_nxt;
    end
  end

  assign dn_data = '{acc: C4, arg: arg_r, neg: neg_r};

  `SCPA_ASSERT_SAME(a_rem_bound, v_r[2], (rem_r >= -P_S) && (rem_r < P_S + P_S),
                    "reciprocal estimate off by more than one")
  `SCPA_ASSERT_SAME(a_arg_bound, v_r[3], arg_r <= ARG_MAX,
                    "reduced argument above pi/2")
  `SCPA_ASSERT_NEXT(a_stage_hold, v_r[NS-1] && !dn_ready, v_r[NS-1] && $stable(arg_r),
                    "stalled reduction result changed")

endmodule

// File: hdl/scpa_horner_step.sv
// One two-stage Horner step: multiply by the argument, round, add a coefficient.
module scpa_horner_step (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  scpa_pkg::hrn_t up_data,
  input  scpa_pkg::acc_t coef,
  output logic           dn_valid,
  input  logic           dn_ready,
  output scpa_pkg::hrn_t dn_data
);
  import scpa_pkg::*;

  localparam int NS = 2;

  logic [NS-1:0] v_r;
  logic [NS:0]   en;

  logic signed [PROD_W-1:0] prod_nxt, prod_r, rsum;
  acc_t                     acc_nxt, acc_r;
  arg_t                     arg_a_r, arg_b_r;
  logic                     neg_a_r, neg_b_r;

  always_comb begin
    en[NS] = dn_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= (en[NS-1:0] & {v_r[NS-2:0], up_valid}) | (~en[NS-1:0] & v_r);
    end
  end

  assign prod_nxt = $signed(up_data.acc) * $signed({1'b0, up_data.arg});

  // Round half up back to 30 fraction bits, then add the next coefficient.
  assign rsum    = prod_r + ROUND_HALF;
  assign acc_nxt = $signed(rsum[COEF_FRAC +: ACC_W]) + coef;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_r  <= prod_nxt;
      arg_a_r <= up_data.arg;
      neg_a_r <= up_data.neg;
    end
    if (en[1]) begin
      acc_r   <= acc_nxt;
      arg_b_r <= arg_a_r;
      neg_b_r <= neg_a_r;
    end
  end

  assign dn_data = '{acc: acc_r, arg: arg_b_r, neg: neg_b_r};

endmodule

// File: hdl/sine_cosine_poly_approx_unit.sv
// Top level of the pipelined polynomial sine/cosine approximation unit.
// The input channel in_chan carries func (0 sine, 1 cosine) and a signed angle
// in radians with ANGLE_FRAC_BITS fraction bits; the output channel out_chan
// carries the signed result with RESULT_FRAC_BITS fraction bits. A transfer
// takes place on a rising edge with valid and ready both high.
// An input transfer reaches out_chan after passing through 13 register
// stages: four stages of range reduction (operand select, reciprocal
// multiply, remainder, fold), two stages for each of the four Horner steps
// (multiply, then round and add), and one output register for rounding,
// sign and saturation. While the output is not stalled, one angle is
// taken in every cycle, so throughput is one result per cycle, since
// every stage accepts a new item in each cycle.
// Each stage carries its own valid bit and loads when it is empty or its
// content moves on, so empty slots close up while the receiver stalls and
// in_chan.ready falls only when all 13 stages hold results. A stalled result
// stays on out_chan unchanged until it is transferred.
// Reset clears every valid bit; data registers are not reset.
`include "sine_cosine_poly_approx_unit_defines.svh"

module sine_cosine_poly_approx_unit #(
  parameter int ANGLE_FRAC_BITS  = scpa_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int RESULT_FRAC_BITS = scpa_pkg::RESULT_FRAC_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  scpa_in_if.sink     in_chan,
  scpa_out_if.source  out_chan
);
  import scpa_pkg::*;

  // Final rounding shift from the Q2.30 accumulator to the result format.
  localparam int SH    = COEF_FRAC - RESULT_FRAC_BITS;
  localparam int CMP_W = ACC_W + 2;

  localparam logic signed [CMP_W-1:0] Y_HALF  = CMP_W'(1) << (SH - 1);
  localparam logic signed [CMP_W-1:0] VAL_MAX = CMP_W'((1 << (VALUE_W - 1)) - 1);
  localparam logic signed [CMP_W-1:0] VAL_MIN = -VAL_MAX - CMP_W'(1);
  // Largest magnitude the polynomial can reach, with some margin.
  localparam logic signed [CMP_W-1:0] VAL_LIM =
    (CMP_W'(1) << RESULT_FRAC_BITS) + (CMP_W'(1) << (RESULT_FRAC_BITS - 4));

  logic [HORNER_STEPS:0] hv;
  logic [HORNER_STEPS:0] hr;
  hrn_t                  hd [HORNER_STEPS+1];

  logic                      en_f;
  logic                      vf_r;
  acc_t                      acc_f;
  logic signed [CMP_W-1:0]   ysum, ysh, ysg;
  logic signed [VALUE_W-1:0] value_nxt, value_r;

  // Range reduction: angle to argument in [0, pi/2] plus the result sign.
  scpa_range_reduce #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_chan.valid),
    .up_ready (in_chan.ready),
    .func     (in_chan.func),
    .angle    (in_chan.angle),
    .dn_valid (hv[0]),
    .dn_ready (hr[0]),
    .dn_data  (hd[0])
  );

  // Horner evaluation of the fourth-degree polynomial, one step per pair of stages.
  for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_horner
    scpa_horner_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (hv[i]),
      .up_ready (hr[i]),
      .up_data  (hd[i]),
      .coef     (HORNER_ADD[i]),
      .dn_valid (hv[i+1]),
      .dn_ready (hr[i+1]),
      .dn_data  (hd[i+1])
    );
  end

  // Output stage: it loads whenever it is empty or its result is transferred.
  assign en_f             = !vf_r || out_chan.ready;
  assign hr[HORNER_STEPS] = en_f;
  assign acc_f            = hd[HORNER_STEPS].acc;

  // Round half up to the result format, apply the sign, then saturate.
  always_comb begin
    ysum = $signed({{(CMP_W - ACC_W){acc_f[ACC_W-1]}}, acc_f}) + Y_HALF;
    ysh  = ysum >>> SH;
    ysg  = hd[HORNER_STEPS].neg ? -ysh : ysh;
    priority if (ysg > VAL_MAX) begin
      value_nxt = VAL_MAX[VALUE_W-1:0];
    end else if (ysg < VAL_MIN) begin
      value_nxt = VAL_MIN[VALUE_W-1:0];
    end else begin
      value_nxt = ysg[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en_f) begin
      vf_r <= hv[HORNER_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      value_r <= value_nxt;
    end
  end

  assign out_chan.valid = vf_r;
  assign out_chan.value = value_r;

  // The input side may only be held off by a full pipeline behind a stalled output.
  `SCPA_ASSERT_SAME(a_stall_cause, !in_chan.ready, out_chan.valid && !out_chan.ready,
                    "input stalled without a stalled output")
  `SCPA_ASSERT_SAME(a_value_range, out_chan.valid,
                    (value_r <= VAL_LIM) && (value_r >= -VAL_LIM),
                    "result magnitude beyond one")
  `SCPA_ASSERT_RESET(a_reset_empty, !rst_n, !out_chan.valid,
                     "output valid right after reset")

endmodule
